// ===== rtl/dual_integrator_pid_step_assert.svh =====
// Assertion macros used by the controller top level.
`ifndef DUAL_INTEGRATOR_PID_STEP_ASSERT_SVH
`define DUAL_INTEGRATOR_PID_STEP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define DIPID_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define DIPID_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dipid_pkg.sv =====
// Types, widths and register indexes of the dual-integrator PID controller.
package dipid_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I_FIRST   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I_SECOND  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_CAP      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_FLOOR   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ANTI_WINDUP_EN = 3'd7;

    // Datapath widths
    localparam int IN_W    = 16;  // sample fields
    localparam int GAIN_W  = 16;  // Q8.8 gains
    localparam int LIM_W   = 15;  // output limit
    localparam int CAP_W   = 31;  // integral caps
    localparam int FRAC_W  = 8;   // fraction bits of internal terms
    localparam int ERR_W   = 17;  // target - measured
    localparam int DERR_W  = 18;  // err - previous err
    localparam int MUL_A_W = 16;  // multiplier gain operand
    localparam int MUL_B_W = 33;  // multiplier data operand
    localparam int MUL_P_W = 49;  // full product
    localparam int P_W     = 33;  // proportional term
    localparam int T1_W    = 33;  // first integral term
    localparam int T2_W    = 41;  // second integral term after rescale
    localparam int D_W     = 34;  // derivative term
    localparam int PD_W    = 35;  // P + D
    localparam int ACC_W   = 32;  // accumulators
    localparam int ASUM_W  = 33;  // acc1 + acc2
    localparam int N1_W    = 34;  // acc1 + t1
    localparam int N2_W    = 42;  // acc2 + t2
    localparam int PRE_W   = 36;  // P + D + acc1 + acc2

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I1,
        ST_MUL_I2,
        ST_MUL_D,
        ST_PRE,
        ST_LIMIT,
        ST_ACCUM,
        ST_SUM,
        ST_CLAMP
    } state_t;

    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I1,
        MSEL_I2,
        MSEL_D
    } mul_sel_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i_first;
        logic signed [GAIN_W-1:0] gain_i_second;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         output_limit;
        logic [CAP_W-1:0]         first_integral_cap;
        logic [CAP_W-1:0]         second_integral_floor;
        logic                     anti_windup_enable;
    } cfg_t;

    typedef struct packed {
        logic     accept;    // take the input word
        mul_sel_t mul_sel;   // multiplier operand pair
        logic     ld_p;      // capture proportional product
        logic     ld_t1;     // capture first integral product
        logic     ld_t2;     // capture rescaled second product
        logic     ld_pre;    // capture P + D and acc1 + acc2
        logic     ld_limit;  // apply windup limiting
        logic     ld_acc;    // accumulate with saturation
        logic     ld_sum;    // form the output sum
        logic     ld_out;    // clamp and present the result word
    } ctrl_t;

endpackage

// ===== rtl/dipid_cfg.sv =====
// Configuration register bank of the PID controller.
module dipid_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [dipid_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dipid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output dipid_pkg::cfg_t                     cfg
);

    localparam int GAIN_W = dipid_pkg::GAIN_W;
    localparam int LIM_W  = dipid_pkg::LIM_W;
    localparam int CAP_W  = dipid_pkg::CAP_W;

    dipid_pkg::cfg_t cfg_reg;

    // Write the addressed register; hold all others
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p                <= '0;
            cfg_reg.gain_i_first          <= '0;
            cfg_reg.gain_i_second         <= '0;
            cfg_reg.gain_d                <= '0;
            cfg_reg.output_limit          <= '1;
            cfg_reg.first_integral_cap    <= '1;
            cfg_reg.second_integral_floor <= '1;
            cfg_reg.anti_windup_enable    <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_index)
                dipid_pkg::REG_GAIN_P: begin
                    cfg_reg.gain_p <= $signed(cfg_wdata[GAIN_W-1:0]);
                end
                dipid_pkg::REG_GAIN_I_FIRST: begin
                    cfg_reg.gain_i_first <= $signed(cfg_wdata[GAIN_W-1:0]);
                end
                dipid_pkg::REG_GAIN_I_SECOND: begin
                    cfg_reg.gain_i_second <= $signed(cfg_wdata[GAIN_W-1:0]);
                end
                dipid_pkg::REG_GAIN_D: begin
                    cfg_reg.gain_d <= $signed(cfg_wdata[GAIN_W-1:0]);
                end
                dipid_pkg::REG_OUTPUT_LIMIT: begin
                    cfg_reg.output_limit <= cfg_wdata[LIM_W-1:0];
                end
                dipid_pkg::REG_FIRST_CAP: begin
                    cfg_reg.first_integral_cap <= cfg_wdata[CAP_W-1:0];
                end
                dipid_pkg::REG_SECOND_FLOOR: begin
                    cfg_reg.second_integral_floor <= cfg_wdata[CAP_W-1:0];
                end
                dipid_pkg::REG_ANTI_WINDUP_EN: begin
                    cfg_reg.anti_windup_enable <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dipid_mul.sv =====
// Shared signed gain-by-data multiplier with a registered product.
module dipid_mul (
    input  logic                                  aclk,
    input  logic signed [dipid_pkg::MUL_A_W-1:0]  mul_a,
    input  logic signed [dipid_pkg::MUL_B_W-1:0]  mul_b,
    output logic signed [dipid_pkg::MUL_P_W-1:0]  prod_reg
);

    localparam int MUL_P_W = dipid_pkg::MUL_P_W;

    logic signed [MUL_P_W-1:0] prod_next;

    // Form the full-width product
    assign prod_next = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // Register the product
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ===== rtl/dipid_ctrl.sv =====
// Step sequencer that drives the shared multiplier and the datapath loads.
module dipid_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             out_free,
    output logic             s_ready,
    output dipid_pkg::ctrl_t ctrl
);

    dipid_pkg::state_t state_reg;
    dipid_pkg::state_t state_next;

    // Advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dipid_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dipid_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = dipid_pkg::ST_MUL_P;
                end
            end
            dipid_pkg::ST_MUL_P:  state_next = dipid_pkg::ST_MUL_I1;
            dipid_pkg::ST_MUL_I1: state_next = dipid_pkg::ST_MUL_I2;
            dipid_pkg::ST_MUL_I2: state_next = dipid_pkg::ST_MUL_D;
            dipid_pkg::ST_MUL_D:  state_next = dipid_pkg::ST_PRE;
            dipid_pkg::ST_PRE:    state_next = dipid_pkg::ST_LIMIT;
            dipid_pkg::ST_LIMIT:  state_next = dipid_pkg::ST_ACCUM;
            dipid_pkg::ST_ACCUM:  state_next = dipid_pkg::ST_SUM;
            dipid_pkg::ST_SUM:    state_next = dipid_pkg::ST_CLAMP;
            dipid_pkg::ST_CLAMP: begin
                // hold until the output register is free
                if (out_free) begin
                    state_next = dipid_pkg::ST_IDLE;
                end
            end
            default: state_next = dipid_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready       = 1'b0;
        ctrl          = '0;
        ctrl.mul_sel  = dipid_pkg::MSEL_P;
        case (state_reg)
            dipid_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                ctrl.accept = s_valid;
            end
            dipid_pkg::ST_MUL_P: begin
                ctrl.mul_sel = dipid_pkg::MSEL_P;
            end
            dipid_pkg::ST_MUL_I1: begin
                ctrl.mul_sel = dipid_pkg::MSEL_I1;
                ctrl.ld_p    = 1'b1;
            end
            dipid_pkg::ST_MUL_I2: begin
                ctrl.mul_sel = dipid_pkg::MSEL_I2;
                ctrl.ld_t1   = 1'b1;
            end
            dipid_pkg::ST_MUL_D: begin
                ctrl.mul_sel = dipid_pkg::MSEL_D;
                ctrl.ld_t2   = 1'b1;
            end
            dipid_pkg::ST_PRE: begin
                ctrl.ld_pre = 1'b1;
            end
            dipid_pkg::ST_LIMIT: begin
                ctrl.ld_limit = 1'b1;
            end
            dipid_pkg::ST_ACCUM: begin
                ctrl.ld_acc = 1'b1;
            end
            dipid_pkg::ST_SUM: begin
                ctrl.ld_sum = 1'b1;
            end
            dipid_pkg::ST_CLAMP: begin
                ctrl.ld_out = out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/dual_integrator_pid_step.sv =====
// Top level of the dual-integrator PID controller with anti-windup.
// Each sample word (measured, target) yields one drive word. A sample is
// taken while the sequencer is idle, and the sequencer returns to idle
// once the drive word is loaded into the output register. The single
// shared 16x33 multiplier forms P, t1, t2 and D one after another,
// followed by the pre-sum, limiting, accumulate, sum and clamp steps.
// A finished drive word waits in the output register, so the next
// sample may be taken before it is read; a stalled output holds the
// sequencer in its clamp step. Configuration writes belong in idle time.
module dual_integrator_pid_step (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [dipid_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dipid_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [dipid_pkg::IN_W-1:0]      s_measured_value,
    input  logic signed [dipid_pkg::IN_W-1:0]      s_target_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [dipid_pkg::IN_W-1:0]      m_drive_value
);

    `include "dual_integrator_pid_step_assert.svh"

    localparam int IN_W    = dipid_pkg::IN_W;
    localparam int FRAC_W  = dipid_pkg::FRAC_W;
    localparam int ERR_W   = dipid_pkg::ERR_W;
    localparam int DERR_W  = dipid_pkg::DERR_W;
    localparam int MUL_A_W = dipid_pkg::MUL_A_W;
    localparam int MUL_B_W = dipid_pkg::MUL_B_W;
    localparam int MUL_P_W = dipid_pkg::MUL_P_W;
    localparam int P_W     = dipid_pkg::P_W;
    localparam int T1_W    = dipid_pkg::T1_W;
    localparam int T2_W    = dipid_pkg::T2_W;
    localparam int D_W     = dipid_pkg::D_W;
    localparam int PD_W    = dipid_pkg::PD_W;
    localparam int ACC_W   = dipid_pkg::ACC_W;
    localparam int ASUM_W  = dipid_pkg::ASUM_W;
    localparam int N1_W    = dipid_pkg::N1_W;
    localparam int N2_W    = dipid_pkg::N2_W;
    localparam int PRE_W   = dipid_pkg::PRE_W;

    dipid_pkg::cfg_t  cfg;
    dipid_pkg::ctrl_t ctrl;
    logic             out_free;

    // Datapath registers
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DERR_W-1:0]  derr_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [T1_W-1:0]    t1_reg;
    logic signed [T1_W-1:0]    t1_next;
    logic signed [T2_W-1:0]    t2_reg;
    logic signed [T2_W-1:0]    t2_next;
    logic signed [PD_W-1:0]    pd_reg;
    logic signed [ASUM_W-1:0]  asum_reg;
    logic signed [ACC_W-1:0]   acc1_reg;
    logic signed [ACC_W-1:0]   acc1_next;
    logic signed [ACC_W-1:0]   acc2_reg;
    logic signed [ACC_W-1:0]   acc2_next;
    logic signed [PRE_W-1:0]   sum_reg;
    logic signed [IN_W-1:0]    drive_reg;
    logic signed [IN_W-1:0]    drive_next;
    logic                      m_valid_reg;

    // Combinational terms
    logic signed [ERR_W-1:0]   err_w;
    logic signed [DERR_W-1:0]  derr_w;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [PRE_W-1:0]   lim_w;
    logic signed [PRE_W-1:0]   lim_neg_w;
    logic signed [PRE_W-1:0]   pre_w;
    logic signed [N1_W-1:0]    nx1_w;
    logic signed [N2_W-1:0]    nx2_w;
    logic signed [ACC_W-1:0]   sat1_w;
    logic signed [ACC_W-1:0]   sat2_w;
    logic signed [IN_W-1:0]    m_pos_w;
    logic signed [IN_W-1:0]    m_neg_w;
    logic                      over_w;
    logic                      hit1_w;
    logic                      hit2_w;
    logic                      same1_w;
    logic                      same2_w;
    logic                      limit_en_w;

    dipid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dipid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    dipid_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Error and error difference of the incoming word
    assign err_w  = ERR_W'(s_target_value) - ERR_W'(s_measured_value);
    assign derr_w = DERR_W'(err_w) - DERR_W'(prev_err_reg);

    // Select the multiplier operands; t2 takes t1 straight from the product
    always_comb begin
        case (ctrl.mul_sel)
            dipid_pkg::MSEL_P: begin
                mul_a = cfg.gain_p;
                mul_b = MUL_B_W'(err_reg);
            end
            dipid_pkg::MSEL_I1: begin
                mul_a = cfg.gain_i_first;
                mul_b = MUL_B_W'(err_reg);
            end
            dipid_pkg::MSEL_I2: begin
                mul_a = cfg.gain_i_second;
                mul_b = $signed(prod_reg[T1_W-1:0]);
            end
            dipid_pkg::MSEL_D: begin
                mul_a = cfg.gain_d;
                mul_b = MUL_B_W'(derr_reg);
            end
            default: begin
                mul_a = cfg.gain_p;
                mul_b = MUL_B_W'(err_reg);
            end
        endcase
    end

    // Output limit in internal units and as a drive word
    assign lim_w     = $signed(PRE_W'({cfg.output_limit, {FRAC_W{1'b0}}}));
    assign lim_neg_w = -lim_w;
    assign m_pos_w   = $signed(IN_W'(cfg.output_limit));
    assign m_neg_w   = -m_pos_w;

    // Windup tests on the accumulators as they stand before the update
    assign pre_w   = PRE_W'(pd_reg) + PRE_W'(asum_reg);
    assign over_w  = (pre_w > lim_w) || (pre_w < lim_neg_w);
    assign nx1_w   = N1_W'(acc1_reg) + N1_W'(t1_reg);
    assign nx2_w   = N2_W'(acc2_reg) + N2_W'(t2_reg);
    assign hit1_w  = nx1_w > $signed(N1_W'(cfg.first_integral_cap));
    assign hit2_w  = nx2_w < -$signed(N2_W'(cfg.second_integral_floor));
    assign same1_w = (err_reg != '0) && (acc1_reg != '0)
                     && (err_reg[ERR_W-1] == acc1_reg[ACC_W-1]);
    assign same2_w = (err_reg != '0) && (acc2_reg != '0)
                     && (err_reg[ERR_W-1] == acc2_reg[ACC_W-1]);
    assign limit_en_w = ctrl.ld_limit && cfg.anti_windup_enable;

    // Saturate the accumulator sums to 32 bits
    assign sat1_w = ((&nx1_w[N1_W-1:ACC_W-1]) || !(|nx1_w[N1_W-1:ACC_W-1]))
                    ? nx1_w[ACC_W-1:0]
                    : {nx1_w[N1_W-1], {(ACC_W-1){~nx1_w[N1_W-1]}}};
    assign sat2_w = ((&nx2_w[N2_W-1:ACC_W-1]) || !(|nx2_w[N2_W-1:ACC_W-1]))
                    ? nx2_w[ACC_W-1:0]
                    : {nx2_w[N2_W-1], {(ACC_W-1){~nx2_w[N2_W-1]}}};

    // Integral terms: capture products, drop them when limiting calls for it
    always_comb begin
        t1_next = t1_reg;
        t2_next = t2_reg;
        if (ctrl.ld_t1) begin
            t1_next = $signed(prod_reg[T1_W-1:0]);
        end else if (limit_en_w && (hit1_w || (over_w && same1_w))) begin
            t1_next = '0;
        end
        if (ctrl.ld_t2) begin
            // floor of the product over 256
            t2_next = $signed(prod_reg[MUL_P_W-1:FRAC_W]);
        end else if (limit_en_w && (hit2_w || (over_w && same2_w))) begin
            t2_next = '0;
        end
    end

    // Accumulators: pin to a cap when hit, then add with saturation
    always_comb begin
        acc1_next = acc1_reg;
        acc2_next = acc2_reg;
        if (limit_en_w && hit1_w) begin
            acc1_next = $signed(ACC_W'(cfg.first_integral_cap));
        end else if (ctrl.ld_acc) begin
            acc1_next = sat1_w;
        end
        if (limit_en_w && hit2_w) begin
            acc2_next = -$signed(ACC_W'(cfg.second_integral_floor));
        end else if (ctrl.ld_acc) begin
            acc2_next = sat2_w;
        end
    end

    // Clamp the sum to the output limit, else drop the fraction bits
    always_comb begin
        if (sum_reg > lim_w) begin
            drive_next = m_pos_w;
        end else if (sum_reg < lim_neg_w) begin
            drive_next = m_neg_w;
        end else begin
            drive_next = $signed(sum_reg[FRAC_W+IN_W-1:FRAC_W]);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            err_reg  <= err_w;
            derr_reg <= derr_w;
        end
        if (ctrl.ld_p) begin
            p_reg <= $signed(prod_reg[P_W-1:0]);
        end
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        if (ctrl.ld_pre) begin
            pd_reg   <= PD_W'(p_reg) + PD_W'($signed(prod_reg[D_W-1:0]));
            asum_reg <= ASUM_W'(acc1_reg) + ASUM_W'(acc2_reg);
        end
        if (ctrl.ld_sum) begin
            sum_reg <= PRE_W'(pd_reg) + PRE_W'(acc1_reg) + PRE_W'(acc2_reg);
        end
        if (ctrl.ld_out) begin
            drive_reg <= drive_next;
        end
    end

    // Controller state and output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc1_reg     <= '0;
            acc2_reg     <= '0;
            prev_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            acc1_reg <= acc1_next;
            acc2_reg <= acc2_next;
            if (ctrl.accept) begin
                prev_err_reg <= err_w;
            end
            if (ctrl.ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = drive_reg;

    `DIPID_ASSERT_IMP(a_drive_in_limit, m_valid,
        (m_drive_value <= m_pos_w) && (m_drive_value >= m_neg_w),
        "drive word outside the output limit")
    `DIPID_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "input taken again right after an accepted word")
    `DIPID_ASSERT_IMP(a_load_only_when_free, ctrl.ld_out, !m_valid_reg || m_ready,
        "result loaded over a pending drive word")

endmodule

// ===== tb/dual_integrator_pid_step_tb.sv =====
// Self-checking testbench for the dual-integrator PID controller with anti-windup.
`timescale 1ns / 100ps

module dual_integrator_pid_step_tb;

    localparam int IN_W        = dipid_pkg::IN_W;
    localparam int CFG_INDEX_W = dipid_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = dipid_pkg::CFG_DATA_W;
    localparam int FRAC_W      = dipid_pkg::FRAC_W;
    localparam int GAIN_W      = dipid_pkg::GAIN_W;
    localparam int LIM_W       = dipid_pkg::LIM_W;
    localparam int CAP_W       = dipid_pkg::CAP_W;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_STALL     = 300;
    localparam int PHASE_SAMPLES  = 145;
    localparam longint ACC_HI     = 64'sd2147483647;
    localparam longint ACC_LO     = -64'sd2147483648;

    typedef struct packed {
        logic signed [IN_W-1:0] meas;
        logic signed [IN_W-1:0] targ;
    } sample_t;

    typedef enum {
        CFG_MODERATE_AW,
        CFG_MODERATE_FREE,
        CFG_EDGES,
        CFG_ANY
    } cfg_kind_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_measured_value = '0;
    logic signed [IN_W-1:0] s_target_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [IN_W-1:0] m_drive_value;

    dual_integrator_pid_step uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_value (s_measured_value),
        .s_target_value   (s_target_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_value    (m_drive_value)
    );

    // Shadow of the controller registers
    longint cfg_gp = 0, cfg_gi1 = 0, cfg_gi2 = 0, cfg_gd = 0;
    longint cfg_lim = 32767, cfg_cap = ACC_HI, cfg_floor = ACC_HI;
    bit     cfg_aw = 1'b0;

    // Shadow of the controller state
    longint acc1 = 0, acc2 = 0, prev_err = 0;

    sample_t                sample_q[$];
    logic signed [IN_W-1:0] drive_q[$];
    logic                   sample_fire = 1'b0;
    int                     send_idle_pct = 0;
    int                     rcv_idle_pct = 0;
    int                     hold_requests = 0;
    int                     hold_served = 0;
    int                     stall_left = 0;
    int                     idle_cycles = 0;
    int                     mismatches = 0;
    int                     checked = 0;
    int                     settings = 0;
    logic signed [IN_W-1:0] setpoint = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int sign_of(longint x);
        return (x > 0) - (x < 0);
    endfunction

    function automatic longint clip32(longint x);
        if (x > ACC_HI) return ACC_HI;
        if (x < ACC_LO) return ACC_LO;
        return x;
    endfunction

    // Advance the controller shadow by one sample and return its drive word
    function automatic logic signed [IN_W-1:0] pid_next_drive(
        input logic signed [IN_W-1:0] meas,
        input logic signed [IN_W-1:0] targ
    );
        longint err, lim, p, t1, t2, d, next1, next2, pre, mag, sum, drv;
        err = longint'(targ) - longint'(meas);
        lim = cfg_lim * 256;
        p   = cfg_gp * err;
        t1  = cfg_gi1 * err;
        t2  = (cfg_gi2 * t1) >>> FRAC_W;
        d   = cfg_gd * (err - prev_err);
        if (cfg_aw) begin
            next1 = acc1 + t1;
            next2 = acc2 + t2;
            pre   = p + acc1 + acc2 + d;
            mag   = (pre < 0) ? -pre : pre;
            // conditional integration while the output is pinned
            if (mag > lim) begin
                if (sign_of(err) * sign_of(acc1) > 0) t1 = 0;
                if (sign_of(err) * sign_of(acc2) > 0) t2 = 0;
            end
            if (next1 > cfg_cap) begin
                t1   = 0;
                acc1 = cfg_cap;
            end
            if (next2 < -cfg_floor) begin
                t2   = 0;
                acc2 = -cfg_floor;
            end
        end
        acc1 = clip32(acc1 + t1);
        acc2 = clip32(acc2 + t2);
        sum  = p + acc1 + acc2 + d;
        if (sum > lim) drv = cfg_lim;
        else if (sum < -lim) drv = -cfg_lim;
        else drv = sum >>> FRAC_W;
        prev_err = err;
        return drv[IN_W-1:0];
    endfunction

    // Drive one register write and track it in the shadow
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            dipid_pkg::REG_GAIN_P:         cfg_gp    = longint'($signed(data[GAIN_W-1:0]));
            dipid_pkg::REG_GAIN_I_FIRST:   cfg_gi1   = longint'($signed(data[GAIN_W-1:0]));
            dipid_pkg::REG_GAIN_I_SECOND:  cfg_gi2   = longint'($signed(data[GAIN_W-1:0]));
            dipid_pkg::REG_GAIN_D:         cfg_gd    = longint'($signed(data[GAIN_W-1:0]));
            dipid_pkg::REG_OUTPUT_LIMIT:   cfg_lim   = longint'(data[LIM_W-1:0]);
            dipid_pkg::REG_FIRST_CAP:      cfg_cap   = longint'(data[CAP_W-1:0]);
            dipid_pkg::REG_SECOND_FLOOR:   cfg_floor = longint'(data[CAP_W-1:0]);
            dipid_pkg::REG_ANTI_WINDUP_EN: cfg_aw    = data[0];
            default: ;
        endcase
    endtask

    // Write all registers; bits above each register's width carry junk
    task automatic apply_config(int gp, int gi1, int gi2, int gd, int lim, int cap,
                                int flr, bit aw);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(dipid_pkg::REG_GAIN_P, {junk[30:16], gp[15:0]});
        junk = CFG_DATA_W'($urandom);
        write_reg(dipid_pkg::REG_GAIN_I_FIRST, {junk[30:16], gi1[15:0]});
        junk = CFG_DATA_W'($urandom);
        write_reg(dipid_pkg::REG_GAIN_I_SECOND, {junk[30:16], gi2[15:0]});
        junk = CFG_DATA_W'($urandom);
        write_reg(dipid_pkg::REG_GAIN_D, {junk[30:16], gd[15:0]});
        junk = CFG_DATA_W'($urandom);
        write_reg(dipid_pkg::REG_OUTPUT_LIMIT, {junk[30:15], lim[14:0]});
        write_reg(dipid_pkg::REG_FIRST_CAP, cap[30:0]);
        write_reg(dipid_pkg::REG_SECOND_FLOOR, flr[30:0]);
        junk = CFG_DATA_W'($urandom);
        write_reg(dipid_pkg::REG_ANTI_WINDUP_EN, {junk[30:1], aw});
        @(negedge aclk);
        cfg_wen <= 1'b0;
        settings++;
    endtask

    function automatic int edge_gain();
        case ($urandom_range(4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] edge_field();
        case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    task automatic randomize_config(cfg_kind_t kind);
        int mid_gain[4];
        foreach (mid_gain[i]) mid_gain[i] = int'($urandom_range(1024)) - 512;
        case (kind)
            CFG_MODERATE_AW, CFG_MODERATE_FREE:
                apply_config(mid_gain[0], mid_gain[1], mid_gain[2], mid_gain[3],
                             $urandom_range(4000), $urandom_range(1 << 20),
                             $urandom_range(1 << 20), kind == CFG_MODERATE_AW);
            CFG_EDGES:
                apply_config(edge_gain(), edge_gain(), edge_gain(), edge_gain(),
                             ($urandom_range(1)) ? 0 : 32767,
                             ($urandom_range(1)) ? 0 : 32'h7fffffff,
                             ($urandom_range(1)) ? 0 : 32'h7fffffff,
                             1'($urandom_range(1)));
            default:
                apply_config($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, 1'($urandom_range(1)));
        endcase
    endtask

    task automatic push_sample(logic signed [IN_W-1:0] meas, logic signed [IN_W-1:0] targ);
        sample_t s;
        s.meas = meas;
        s.targ = targ;
        sample_q.push_back(s);
    endtask

    // Mostly a loop tracking a held setpoint, plus full-range and edge words
    task automatic push_random_samples(int n);
        int r;
        int delta;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 5) setpoint = IN_W'($urandom);
            if (r < 70) begin
                delta = int'($urandom_range(600)) - 300;
                push_sample(setpoint + 16'(delta), setpoint);
            end else if (r < 90) begin
                push_sample(IN_W'($urandom), IN_W'($urandom));
            end else begin
                push_sample(edge_field(), edge_field());
            end
        end
    endtask

    // Hold until every queued word has gone in and every drive word is back
    task automatic wait_drained();
        do @(posedge aclk);
        while (sample_q.size() != 0 || s_valid || drive_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: offer the next word, hold it until taken
    always @(negedge aclk) begin : drive_samples
        sample_t nxt;
        if (!s_valid || sample_fire) begin
            if (aresetn && sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = sample_q.pop_front();
                s_valid          <= 1'b1;
                s_measured_value <= nxt.meas;
                s_target_value   <= nxt.targ;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            stall_left  <= LONG_STALL;
            m_ready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor: predict on each accepted sample, check each drive word
    always @(posedge aclk) begin : check_drive
        logic signed [IN_W-1:0] want;
        sample_fire <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            drive_q.push_back(pid_next_drive(s_measured_value, s_target_value));
        if (aresetn && m_valid && m_ready) begin
            if (drive_q.size() == 0) begin
                $error("drive_value: no sample pending, actual %0d", m_drive_value);
                mismatches++;
            end else begin
                want = drive_q.pop_front();
                checked++;
                if (m_drive_value !== want) begin
                    $error("drive_value: expected %0d, actual %0d", want, m_drive_value);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wen) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run_test
        cfg_kind_t kinds[9];
        kinds = '{CFG_MODERATE_AW, CFG_EDGES, CFG_MODERATE_FREE, CFG_ANY, CFG_MODERATE_AW,
                  CFG_EDGES, CFG_MODERATE_FREE, CFG_ANY, CFG_MODERATE_AW};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 24;
        rcv_idle_pct  = 45;

        // Reset settings: all gains zero, output stays at zero
        push_sample(16'sh0000, 16'sh0000);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh7fff, 16'sh8000);
        wait_drained();

        // Anti-windup on: clamp, conditional integration, first cap, second floor
        apply_config(256, 64, 128, -256, 1000, 100000, 50000, 1'b1);
        push_sample(16'sd0, 16'sd100);
        push_sample(16'sd0, 16'sd100);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sd100, 16'sd0);
        push_sample(16'sd100, 16'sd0);
        push_sample(16'sd0, 16'sd0);
        push_sample(16'sd5, 16'sd5);
        wait_drained();

        // Extreme gains, limiting off, zero output limit, accumulators saturate
        apply_config(32767, 32767, -32768, -32768, 0, 32'h7fffffff, 32'h7fffffff, 1'b0);
        repeat (3) push_sample(16'sh8000, 16'sh7fff);
        repeat (3) push_sample(16'sh7fff, 16'sh8000);
        wait_drained();

        // Caps at zero with the accumulators still saturated, full output range
        apply_config(-1, 1, -1, 1, 32767, 0, 0, 1'b1);
        push_sample(16'sd0, 16'sd1);
        push_sample(16'sd1, 16'sd0);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sd0, 16'sd0);
        wait_drained();

        // Random phases, each with its own register settings
        for (int ph = 0; ph < 9; ph++) begin
            if (ph / 3 == 0) begin
                send_idle_pct = 24;
                rcv_idle_pct  = 45;
            end else if (ph / 3 == 1) begin
                send_idle_pct = 45;
                rcv_idle_pct  = 24;
            end else begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            randomize_config(kinds[ph]);
            if (ph == 4) begin
                // pause the sender until every drive word is back
                push_random_samples(70);
                wait_drained();
                push_random_samples(PHASE_SAMPLES - 70);
            end else begin
                push_random_samples(PHASE_SAMPLES);
            end
            if (ph == 1) hold_requests++;
            wait_drained();
        end

        if (drive_q.size() != 0)
            $error("drive_value: %0d expected words never arrived", drive_q.size());
        $display("tb: %0d drive words checked across %0d register settings,", checked, settings);
        $display("tb: limiting on and off, edge gains and fields, long stall and input pause");
        if (mismatches == 0 && drive_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
